// ===== rtl/tqm_pkg.sv =====
// Package for the tile quantiser and matcher: sizes, codes and word types.
`default_nettype none
package tqm_pkg;

	// Store geometry
	localparam int MAX_TILES     = 256;
	localparam int ROWS_PER_TILE = 8;
	localparam int ROW_W         = $clog2(ROWS_PER_TILE);
	localparam int CNT_W         = $clog2(MAX_TILES + 1);
	localparam int ADDR_W        = $clog2(MAX_TILES * ROWS_PER_TILE);

	// Register indexes on the configuration port
	localparam logic [1:0] CFG_SHADE_TWO_MIN  = 2'd0;
	localparam logic [1:0] CFG_SHADE_ONE_MIN  = 2'd1;
	localparam logic [1:0] CFG_SHADE_ZERO_MIN = 2'd2;

	// Reset thresholds
	localparam logic [7:0] RST_SHADE_TWO_MIN  = 8'd61;
	localparam logic [7:0] RST_SHADE_ONE_MIN  = 8'd120;
	localparam logic [7:0] RST_SHADE_ZERO_MIN = 8'd180;

	// Shade codes, 0 lightest
	localparam logic [1:0] SHADE_0 = 2'd0;
	localparam logic [1:0] SHADE_1 = 2'd1;
	localparam logic [1:0] SHADE_2 = 2'd2;
	localparam logic [1:0] SHADE_3 = 2'd3;

	// Operation and result kind codes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_MAP     = 1'b1;
	localparam logic KIND_ROW   = 1'b0;
	localparam logic KIND_MATCH = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] pixel_0;
		logic [7:0] pixel_1;
		logic [7:0] pixel_2;
		logic [7:0] pixel_3;
		logic [7:0] pixel_4;
		logic [7:0] pixel_5;
		logic [7:0] pixel_6;
		logic [7:0] pixel_7;
	} in_word_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] low_plane;
		logic [7:0] high_plane;
		logic [7:0] tile_index;
		logic       found;
		logic       store_full;
	} out_word_t;

	typedef struct packed {
		logic [7:0] two_min;
		logic [7:0] one_min;
		logic [7:0] zero_min;
	} shade_cfg_t;

	// One encoded row as kept in the store: high plane over low plane
	typedef struct packed {
		logic [7:0] high_plane;
		logic [7:0] low_plane;
	} row_t;

endpackage
`default_nettype wire

// ===== rtl/tqm_encode.sv =====
// Row encoder: quantises eight grey pixels and packs two bitplane bytes.
`default_nettype none
module tqm_encode (
	input  wire tqm_pkg::in_word_t   word,
	input  wire tqm_pkg::shade_cfg_t cfg,
	output tqm_pkg::row_t            row
);
	import tqm_pkg::*;

	logic [7:0] pix [8];
	logic [1:0] shade [8];

	function automatic logic [1:0] quantise(input logic [7:0] p, input shade_cfg_t c);
		logic [1:0] s;
		if (p >= c.two_min && p < c.one_min)
			s = SHADE_2;
		else if (p >= c.one_min && p < c.zero_min)
			s = SHADE_1;
		else if (p >= c.zero_min)
			s = SHADE_0;
		else
			s = SHADE_3;
		return s;
	endfunction

	// Gather the pixels left to right
	always_comb begin
		pix[0] = word.pixel_0;
		pix[1] = word.pixel_1;
		pix[2] = word.pixel_2;
		pix[3] = word.pixel_3;
		pix[4] = word.pixel_4;
		pix[5] = word.pixel_5;
		pix[6] = word.pixel_6;
		pix[7] = word.pixel_7;
	end

	// Quantise and pack, leftmost pixel in the top bit
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			shade[i]              = quantise(pix[i], cfg);
			row.low_plane[7 - i]  = shade[i][0];
			row.high_plane[7 - i] = shade[i][1];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tile_quantize_and_match.sv =====
// Top level: tile row quantiser, tile store and sequential tile matcher.
//
// Every row is quantised against three thresholds into 2-bit shades and packed into a low
// and a high bitplane byte. A load row is written to the tile store unless it is full, and
// its bytes are registered as a row word; a map row that is not the eighth of its tile
// gives no word. The eighth map row starts a search of the tile store, one stored row per
// cycle with registered read data; the search stops at the first tile that matches, and
// none is made with an empty store. A finished word waits in the output register while one
// more word may be parked in a skid register; input is stalled during a search and while
// the skid register is full. The tile store holds MAX_TILES tiles of eight rows and needs no
// clearing after reset.
`default_nettype none
module tile_quantize_and_match (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic cfg_we,
	input  wire                logic [1:0] cfg_index,
	input  wire                logic [7:0] cfg_data,
	input  wire                logic in_valid,
	output                     logic in_stall,
	input  wire tqm_pkg::in_word_t in_data,
	output                     logic out_valid,
	input  wire                logic out_stall,
	output tqm_pkg::out_word_t out_data
);
	import tqm_pkg::*;

	shade_cfg_t         cfg_q;
	row_t               row;
	logic [15:0]        tile_store [MAX_TILES * ROWS_PER_TILE];
	logic [15:0]        cur_tile_q [ROWS_PER_TILE];
	logic [CNT_W-1:0]   stored_q;
	logic [ROW_W-1:0]   load_row_q;
	logic [ROW_W-1:0]   map_row_q;
	logic               scan_q;
	logic               issue_q;
	logic [ADDR_W-1:0]  raddr_q;
	logic [15:0]        rdata_s1;
	logic               rv_s1;
	logic [ADDR_W-1:0]  raddr_s1;
	logic               ok_q;
	logic               pend_v_q;
	out_word_t          pend_q;
	out_word_t          out_q;
	logic               out_v_q;

	logic               accept;
	logic               full;
	logic               st_we;
	logic [ADDR_W-1:0]  st_waddr;
	logic               map_last;
	logic               scan_start;
	logic [CNT_W+2:0]   rows_stored;
	logic [ADDR_W-1:0]  scan_last;
	logic               row_eq;
	logic               ok_here;
	logic               hit;
	logic               miss_end;
	logic               scan_done;
	logic [ADDR_W+7:0]  raddr_ext;
	logic               new_v;
	out_word_t          new_d;
	logic               out_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.two_min  <= RST_SHADE_TWO_MIN;
			cfg_q.one_min  <= RST_SHADE_ONE_MIN;
			cfg_q.zero_min <= RST_SHADE_ZERO_MIN;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHADE_TWO_MIN:  cfg_q.two_min  <= cfg_data;
				CFG_SHADE_ONE_MIN:  cfg_q.one_min  <= cfg_data;
				CFG_SHADE_ZERO_MIN: cfg_q.zero_min <= cfg_data;
				default: ;
			endcase
		end
	end

	tqm_encode u_encode (
		.word (in_data),
		.cfg  (cfg_q),
		.row  (row)
	);

	// Input handshake and decode
	assign in_stall   = scan_q || pend_v_q;
	assign accept     = in_valid && !in_stall;
	assign full       = (stored_q >= CNT_W'(MAX_TILES));
	assign st_we      = accept && (in_data.operation == OP_LOAD) && !full;
	assign st_waddr   = ADDR_W'({stored_q, load_row_q});
	assign map_last   = accept && (in_data.operation == OP_MAP)
	                    && (map_row_q == ROW_W'(ROWS_PER_TILE - 1));
	assign scan_start = map_last && (stored_q != '0);

	// Row counters and tile count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q   <= '0;
			load_row_q <= '0;
			map_row_q  <= '0;
		end else if (accept) begin
			if (in_data.operation == OP_LOAD) begin
				if (!full) begin
					load_row_q <= load_row_q + ROW_W'(1);
					if (load_row_q == ROW_W'(ROWS_PER_TILE - 1))
						stored_q <= stored_q + CNT_W'(1);
				end
			end else begin
				map_row_q <= map_row_q + ROW_W'(1);
			end
		end
	end

	// Current map tile
	always_ff @(posedge clk) begin
		if (accept && in_data.operation == OP_MAP)
			cur_tile_q[map_row_q] <= row;
	end

	// Tile store: write on load, read for the search
	always_ff @(posedge clk) begin
		if (st_we)
			tile_store[st_waddr] <= row;
		rdata_s1 <= tile_store[raddr_q];
	end

	// Search compare stage
	assign rows_stored = {stored_q, 3'b000};
	assign scan_last   = ADDR_W'(rows_stored - (CNT_W + 3)'(1));
	assign row_eq      = (rdata_s1 == cur_tile_q[raddr_s1[ROW_W-1:0]]);
	assign ok_here     = ((raddr_s1[ROW_W-1:0] == '0) ? 1'b1 : ok_q) && row_eq;
	assign hit         = rv_s1 && (raddr_s1[ROW_W-1:0] == ROW_W'(ROWS_PER_TILE - 1)) && ok_here;
	assign miss_end    = rv_s1 && (raddr_s1 == scan_last) && !ok_here;
	assign scan_done   = hit || miss_end;
	assign raddr_ext   = {8'd0, raddr_s1};

	// Search sequencer: one store row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= 1'b0;
			issue_q  <= 1'b0;
			rv_s1    <= 1'b0;
			raddr_q  <= '0;
			raddr_s1 <= '0;
			ok_q     <= 1'b0;
		end else begin
			rv_s1 <= issue_q;
			if (issue_q) begin
				raddr_s1 <= raddr_q;
				raddr_q  <= raddr_q + ADDR_W'(1);
				if (raddr_q == scan_last)
					issue_q <= 1'b0;
			end
			if (rv_s1)
				ok_q <= ok_here;
			if (scan_start) begin
				scan_q  <= 1'b1;
				issue_q <= 1'b1;
				raddr_q <= '0;
			end
			// drop any read still in flight once the answer is known
			if (scan_done) begin
				scan_q  <= 1'b0;
				issue_q <= 1'b0;
				rv_s1   <= 1'b0;
			end
		end
	end

	// Build the word for this cycle, if any
	always_comb begin
		new_v = 1'b0;
		new_d = '0;
		if (accept && in_data.operation == OP_LOAD) begin
			new_v            = 1'b1;
			new_d.result_kind = KIND_ROW;
			new_d.low_plane  = row.low_plane;
			new_d.high_plane = row.high_plane;
			new_d.store_full = full;
		end else if (map_last && !scan_start) begin
			new_v             = 1'b1;
			new_d.result_kind = KIND_MATCH;
		end else if (scan_done) begin
			new_v             = 1'b1;
			new_d.result_kind = KIND_MATCH;
			new_d.found       = hit;
			new_d.tile_index  = hit ? raddr_ext[ROW_W+7:ROW_W] : 8'd0;
		end
	end

	// Output register with one skid slot
	assign out_free = !out_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (out_free) begin
			if (pend_v_q) begin
				out_v_q  <= 1'b1;
				pend_v_q <= new_v;
			end else begin
				out_v_q  <= new_v;
			end
		end else if (new_v) begin
			pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_v_q) begin
				out_q <= pend_q;
				if (new_v)
					pend_q <= new_d;
			end else if (new_v) begin
				out_q <= new_d;
			end
		end else if (new_v) begin
			pend_q <= new_d;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
